/* src/mric_pkg.sv */
// Package with shared types and constants of the mixed radix index converter.
`default_nettype none
package mric_pkg;

   localparam int NUM_SLOTS = 4;
   localparam int IDX_W     = 31;
   localparam int SUB_W     = 16;
   localparam int CNT_W     = 3;
   localparam int CSR_IDX_W = 3;

   typedef enum logic {
      OP_SPLIT = 1'b0,
      OP_BUILD = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIMS  = 3'd0,
      CSR_SIZE0 = 3'd1,
      CSR_SIZE1 = 3'd2,
      CSR_SIZE2 = 3'd3,
      CSR_SIZE3 = 3'd4
   } csr_index_type;

   typedef struct packed {
      op_type             operation;
      logic [IDX_W-1:0]   in_index;
      logic [SUB_W-1:0]   in_sub0;
      logic [SUB_W-1:0]   in_sub1;
      logic [SUB_W-1:0]   in_sub2;
      logic [SUB_W-1:0]   in_sub3;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]   out_index;
      logic [SUB_W-1:0]   out_sub0;
      logic [SUB_W-1:0]   out_sub1;
      logic [SUB_W-1:0]   out_sub2;
      logic [SUB_W-1:0]   out_sub3;
      logic               overflow;
   } rsp_type;

   // Item state carried from cell to cell.
   typedef struct packed {
      op_type                             op;
      logic [IDX_W-1:0]                   index;
      logic                               ovf;
      logic [IDX_W-1:0]                   work;
      logic [SUB_W-1:0]                   rem;
      logic [NUM_SLOTS-1:0][SUB_W-1:0]    sub;
   } pipe_type;

endpackage
`default_nettype wire

/* src/mric_horner_cell.sv */
// One Horner step of index composition: index = sub + size * index.
`default_nettype none
module mric_horner_cell
   import mric_pkg::*;
#(
   parameter int DIM = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               enable,
   input  wire logic               in_valid,
   input  wire pipe_type           in_data,
   input  wire logic [SUB_W-1:0]   size,
   input  wire logic               active,
   output logic                    out_valid,
   output pipe_type                out_data
);

   logic                           valid_ff;
   pipe_type                       data_ff;
   pipe_type                       data_in;
   logic [IDX_W+SUB_W-1:0]         prod;
   logic [IDX_W+SUB_W:0]           sum;

   always_comb begin
      // The product is taken at its full width so no carry into the flag is lost.
      prod    = size * in_data.index;
      sum     = {1'b0, prod} + (IDX_W+SUB_W+1)'(in_data.sub[DIM]);
      data_in = in_data;
      if (active && in_data.op == OP_BUILD) begin
         data_in.index = sum[IDX_W-1:0];
         data_in.ovf   = (in_data.ovf && size != '0) || (|sum[IDX_W+SUB_W:IDX_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

/* src/mric_div_cell.sv */
// One restoring division step; the last step of a dimension stores its subscript.
`default_nettype none
module mric_div_cell
   import mric_pkg::*;
#(
   parameter int DIM       = 0,
   parameter bit LAST_STEP = 1'b0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               enable,
   input  wire logic               in_valid,
   input  wire pipe_type           in_data,
   input  wire logic [SUB_W-1:0]   size,
   input  wire logic               active,
   output logic                    out_valid,
   output pipe_type                out_data
);

   logic                           valid_ff;
   pipe_type                       data_ff;
   pipe_type                       data_in;
   logic [SUB_W:0]                 trial;
   logic [SUB_W:0]                 diff;
   logic                           fits;
   logic [SUB_W-1:0]               next_rem;
   logic [IDX_W-1:0]               next_work;

   always_comb begin
      trial     = {in_data.rem, in_data.work[IDX_W-1]};
      diff      = trial - {1'b0, size};
      fits      = trial >= {1'b0, size};
      next_rem  = fits ? diff[SUB_W-1:0] : trial[SUB_W-1:0];
      next_work = {in_data.work[IDX_W-2:0], fits};
      data_in      = in_data;
      data_in.rem  = next_rem;
      data_in.work = next_work;
      if (LAST_STEP) begin
         // A zero size gives a zero subscript here and zero quotients above.
         data_in.rem  = '0;
         data_in.work = (size == '0) ? '0 : next_work;
         if (active && in_data.op == OP_SPLIT && size != '0) begin
            data_in.sub[DIM] = next_rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

/* src/mixed_radix_index_converter.sv */
// Top level of the column-major linear index / subscript converter.
//
//   Channel   Ports                         Direction   Moves
//   request   req_valid/req_ready/req_data  in          operation, index, subscripts
//   response  rsp_valid/rsp_ready/rsp_data  out         index, subscripts, overflow
//   config    csr_valid/csr_ready/csr_*     in          register index and value
//
// One transfer is accepted per cycle while the skid register is empty. With D the
// smaller of MAX_DIMS and four, D Horner cells compose the index, then 31
// restoring division cells per dimension peel off subscripts one bit at a time.
// Reset is synchronous and sets one dimension of size one everywhere.
// A stalled response lands in a one-entry skid register; while that register is
// full the whole cell chain holds and req_ready is low.
`default_nettype none
module mixed_radix_index_converter
   import mric_pkg::*;
#(
   parameter int MAX_DIMS = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire req_type                 req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output rsp_type                      rsp_data,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [SUB_W-1:0]        csr_wdata
);

   // Only dimensions that both a size register and MAX_DIMS allow get cells.
   localparam int SLOTS  = (MAX_DIMS < NUM_SLOTS) ? MAX_DIMS : NUM_SLOTS;
   localparam int DSTEPS = SLOTS * IDX_W;
   localparam int STAGES = SLOTS + DSTEPS;

   logic [CNT_W-1:0]                    dims_ff;
   logic [NUM_SLOTS-1:0][SUB_W-1:0]     size_ff;
   logic [CNT_W-1:0]                    dims_eff;
   logic [NUM_SLOTS-1:0]                dim_active;

   logic                                stage_valid [STAGES+1];
   pipe_type                            stage_data  [STAGES+1];
   logic                                enable;

   logic                                skid_valid_ff;
   rsp_type                             skid_data_ff;
   rsp_type                             last_rsp;

   // Configuration registers. Writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= CNT_W'(1);
         size_ff <= {NUM_SLOTS{SUB_W'(1)}};
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DIMS:  dims_ff    <= csr_wdata[CNT_W-1:0];
            CSR_SIZE0: size_ff[0] <= csr_wdata;
            CSR_SIZE1: size_ff[1] <= csr_wdata;
            CSR_SIZE2: size_ff[2] <= csr_wdata;
            CSR_SIZE3: size_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The dimension count is clamped to the number of dimensions with cells.
   always_comb begin
      dims_eff = (dims_ff > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : dims_ff;
      for (int d = 0; d < NUM_SLOTS; d++) begin
         dim_active[d] = CNT_W'(d) < dims_eff;
      end
   end

   // The chain moves whenever the skid register is empty.
   assign enable    = !skid_valid_ff;
   assign req_ready = enable;

   // Entry: the split starts from the index with cleared subscripts, the build
   // carries the input subscripts and an empty running index.
   always_comb begin
      stage_valid[0]     = req_valid;
      stage_data[0].op   = req_data.operation;
      stage_data[0].index = '0;
      stage_data[0].ovf  = 1'b0;
      stage_data[0].work = req_data.in_index;
      stage_data[0].rem  = '0;
      if (req_data.operation == OP_BUILD) begin
         stage_data[0].sub = {req_data.in_sub3, req_data.in_sub2,
                              req_data.in_sub1, req_data.in_sub0};
      end else begin
         stage_data[0].sub = '0;
      end
   end

   // Horner cells run from the slowest dimension down to dimension zero.
   for (genvar k = 0; k < SLOTS; k++) begin : g_horner
      mric_horner_cell #(
         .DIM (SLOTS - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (stage_valid[k]),
         .in_data   (stage_data[k]),
         .size      (size_ff[SLOTS-1-k]),
         .active    (dim_active[SLOTS-1-k]),
         .out_valid (stage_valid[k+1]),
         .out_data  (stage_data[k+1])
      );
   end

   // Division cells: each dimension divides the running quotient by its size.
   for (genvar d = 0; d < SLOTS; d++) begin : g_dim
      for (genvar b = 0; b < IDX_W; b++) begin : g_step
         mric_div_cell #(
            .DIM       (d),
            .LAST_STEP (b == IDX_W - 1)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .enable    (enable),
            .in_valid  (stage_valid[SLOTS + d*IDX_W + b]),
            .in_data   (stage_data[SLOTS + d*IDX_W + b]),
            .size      (size_ff[d]),
            .active    (dim_active[d]),
            .out_valid (stage_valid[SLOTS + d*IDX_W + b + 1]),
            .out_data  (stage_data[SLOTS + d*IDX_W + b + 1])
         );
      end
   end

   // Fields that belong to the other operation read as zero.
   always_comb begin
      last_rsp = '0;
      if (stage_data[STAGES].op == OP_BUILD) begin
         last_rsp.out_index = stage_data[STAGES].index;
         last_rsp.overflow  = stage_data[STAGES].ovf;
      end else begin
         last_rsp.out_sub0  = stage_data[STAGES].sub[0];
         last_rsp.out_sub1  = stage_data[STAGES].sub[1];
         last_rsp.out_sub2  = stage_data[STAGES].sub[2];
         last_rsp.out_sub3  = stage_data[STAGES].sub[3];
      end
   end

   // The skid register catches the chain's output when the consumer stalls;
   // it always holds the older transfer, so it is presented first.
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (stage_valid[STAGES] && !rsp_ready) begin
         skid_valid_ff <= 1'b1;
      end
      if (!skid_valid_ff) begin
         skid_data_ff <= last_rsp;
      end
   end

   assign rsp_valid = skid_valid_ff || stage_valid[STAGES];
   assign rsp_data  = skid_valid_ff ? skid_data_ff : last_rsp;

endmodule
`default_nettype wire

/* tb/mixed_radix_index_converter_test.sv */
// Testbench for the mixed radix index converter: random and corner transfers checked by a scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module mixed_radix_index_converter_test
   import mric_pkg::*;
();

   localparam int MAX_DIMS = 4;
   // The pipeline is D + 31 * D cells deep; leave some margin beyond that.
   localparam int DRAIN_CYCLES = 160;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD = 400;
   localparam int RANDOM_PER_PHASE = 74;
   // Index 7 decodes to no register and must be ignored by the block.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   // Scoreboard: keeps its own copy of the registers, predicts one response
   // per accepted request and compares responses in order.
   class index_scoreboard;
      logic [CNT_W-1:0] dims_reg;
      logic [SUB_W-1:0] size_reg[NUM_SLOTS];
      rsp_type pending[$];
      int errors;
      int checked;

      function new();
         dims_reg = 3'd1;
         for (int d = 0; d < NUM_SLOTS; d++) size_reg[d] = 16'd1;
         errors = 0;
         checked = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [SUB_W-1:0] val);
         if (idx == CSR_DIMS) dims_reg = val[CNT_W-1:0];
         else if (idx >= CSR_SIZE0 && idx <= CSR_SIZE3) size_reg[idx - CSR_SIZE0] = val;
      endfunction

      function int unsigned active_dims();
         int unsigned n;
         n = dims_reg;
         if (n > MAX_DIMS) n = MAX_DIMS;
         if (n > NUM_SLOTS) n = NUM_SLOTS;
         return n;
      endfunction

      // Column-major conversion. The lower product is kept twice: once
      // saturated at 2^31 for the quotient and the overflow test, once
      // wrapping for the truncated composed index.
      function rsp_type convert(req_type r);
         longint unsigned capped, wrapped, sum_wrap, sum_cap, q, s, sz;
         logic [SUB_W-1:0] sub_in[NUM_SLOTS];
         logic [SUB_W-1:0] sub_out[NUM_SLOTS];
         rsp_type o;
         capped = 1;
         wrapped = 1;
         sum_wrap = 0;
         sum_cap = 0;
         sub_in = '{r.in_sub0, r.in_sub1, r.in_sub2, r.in_sub3};
         sub_out = '{default: '0};
         o = '0;
         for (int unsigned d = 0; d < active_dims(); d++) begin
            sz = size_reg[d];
            if (r.operation == OP_SPLIT) begin
               q = (capped == 0) ? 0 : r.in_index / capped;
               sub_out[d] = (sz == 0) ? '0 : SUB_W'(q % sz);
            end else begin
               s = sub_in[d];
               sum_wrap += s * wrapped;
               sum_cap += s * capped;
            end
            wrapped *= sz;
            capped *= sz;
            if (capped > 64'h8000_0000) capped = 64'h8000_0000;
         end
         o.out_sub0 = sub_out[0];
         o.out_sub1 = sub_out[1];
         o.out_sub2 = sub_out[2];
         o.out_sub3 = sub_out[3];
         if (r.operation == OP_BUILD) begin
            o.out_index = sum_wrap[IDX_W-1:0];
            o.overflow = (sum_cap > 64'h7FFF_FFFF);
         end
         return o;
      endfunction

      function void note_request(req_type r);
         pending = {pending, convert(r)};
      endfunction

      task report_mismatch(string what, longint unsigned got, longint unsigned want);
         $display("mismatch on response %0d: %s is 0x%0h, expected 0x%0h",
                  checked, what, got, want);
         errors++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("response 0x%0h arrived with nothing outstanding", got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.out_index !== want.out_index)
            report_mismatch("out_index", got.out_index, want.out_index);
         if (got.out_sub0 !== want.out_sub0) report_mismatch("out_sub0", got.out_sub0, want.out_sub0);
         if (got.out_sub1 !== want.out_sub1) report_mismatch("out_sub1", got.out_sub1, want.out_sub1);
         if (got.out_sub2 !== want.out_sub2) report_mismatch("out_sub2", got.out_sub2, want.out_sub2);
         if (got.out_sub3 !== want.out_sub3) report_mismatch("out_sub3", got.out_sub3, want.out_sub3);
         if (got.overflow !== want.overflow) report_mismatch("overflow", got.overflow, want.overflow);
         checked++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SUB_W-1:0] csr_wdata = '0;

   index_scoreboard board = new();
   // Set for the closing phase: neither side idles any more.
   bit quiet = 1'b0;
   // Asks the response side for one long hold-off so the pipeline fills.
   bit hold_pending = 1'b0;
   int sent = 0;
   int cycles = 0;

   mixed_radix_index_converter #(.MAX_DIMS(MAX_DIMS)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Watchdog. A run that hangs is reported as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses outstanding",
                  cycles, board.pending.size());
         $display("mixed_radix_index_converter_test NOT OK");
         $finish;
      end
   end

   // Every response transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_data);
   end

   // Response side back-pressure: random short stalls, plus a single long
   // hold-off on request so that the skid register fills and req_ready drops.
   initial begin
      @(negedge reset);
      @(posedge clock);
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offers one request and holds it until the transfer happens. Valid is
   // left high afterwards so back-to-back requests follow without a gap.
   task send_request(req_type r);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(r);
      sent++;
   endtask

   task end_burst();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Register writes happen only with the pipeline empty. Each write ends
   // with csr_valid dropped again so consecutive writes never collide in one step.
   task write_csr(logic [CSR_IDX_W-1:0] idx, logic [SUB_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_register(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task wait_drained();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task configure(logic [SUB_W-1:0] dims, logic [SUB_W-1:0] s0, logic [SUB_W-1:0] s1,
                  logic [SUB_W-1:0] s2, logic [SUB_W-1:0] s3);
      write_csr(CSR_DIMS, dims);
      write_csr(CSR_SIZE0, s0);
      write_csr(CSR_SIZE1, s1);
      write_csr(CSR_SIZE2, s2);
      write_csr(CSR_SIZE3, s3);
   endtask

   // Product of the active sizes, or zero when it is zero or out of range.
   function longint unsigned array_volume();
      longint unsigned p;
      p = 1;
      for (int unsigned d = 0; d < board.active_dims(); d++) begin
         p *= board.size_reg[d];
         if (p > 64'h8000_0000) return 0;
      end
      return p;
   endfunction

   function logic [SUB_W-1:0] pick_sub(int d);
      logic [SUB_W-1:0] sz;
      sz = board.size_reg[d];
      case ($urandom_range(0, 5))
         0: return SUB_W'($urandom);
         1: return sz - 16'd1;
         2: return 16'hFFFF;
         default: return (sz == 0) ? SUB_W'($urandom) : SUB_W'($urandom % sz);
      endcase
   endfunction

   function req_type random_request();
      req_type r;
      longint unsigned vol;
      vol = array_volume();
      r.operation = op_type'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
         0: r.in_index = IDX_W'($urandom);
         1: r.in_index = IDX_W'($urandom_range(0, 255));
         2: r.in_index = $urandom_range(0, 1) ? 31'h7FFF_FFFF : '0;
         default: r.in_index = (vol == 0) ? IDX_W'($urandom) : IDX_W'($urandom % vol);
      endcase
      r.in_sub0 = pick_sub(0);
      r.in_sub1 = pick_sub(1);
      r.in_sub2 = pick_sub(2);
      r.in_sub3 = pick_sub(3);
      return r;
   endfunction

   // Corner requests for the current setting: both index extremes, the last
   // element of the array, and subscripts at zero, at size - 1 and at all ones.
   task directed_requests();
      req_type r;
      longint unsigned vol;
      vol = array_volume();
      r = '{OP_SPLIT, 31'd0, 16'd0, 16'd0, 16'd0, 16'd0};
      send_request(r);
      r.in_index = 31'h7FFF_FFFF;
      send_request(r);
      r.in_index = (vol == 0) ? 31'h4000_0000 : IDX_W'(vol - 1);
      send_request(r);
      r = '{OP_BUILD, 31'd0, 16'd0, 16'd0, 16'd0, 16'd0};
      send_request(r);
      r = '{OP_BUILD, 31'd0, board.size_reg[0] - 16'd1, board.size_reg[1] - 16'd1,
            board.size_reg[2] - 16'd1, board.size_reg[3] - 16'd1};
      send_request(r);
      r = '{OP_BUILD, 31'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      send_request(r);
   endtask

   task run_phase(int count);
      directed_requests();
      for (int i = 0; i < count; i++) send_request(random_request());
      end_burst();
      wait_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset setting: one dimension of size one.
      run_phase(RANDOM_PER_PHASE / 2);

      // Ordinary four-dimensional array, with the long response hold-off.
      configure(16'd4, 16'd3, 16'd5, 16'd7, 16'd11);
      hold_pending = 1'b1;
      run_phase(RANDOM_PER_PHASE + 150);

      // Largest sizes: the lower product passes 2^31, builds overflow.
      configure(16'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_phase(RANDOM_PER_PHASE);

      // A zero size in the middle clears every higher subscript.
      configure(16'd4, 16'd16, 16'd0, 16'd9, 16'd9);
      run_phase(RANDOM_PER_PHASE);

      // No dimensions in use: everything reads as zero.
      configure(16'd0, 16'd5, 16'd6, 16'd7, 16'd8);
      run_phase(RANDOM_PER_PHASE / 2);

      // Dimension count beyond four is limited; high csr_wdata bits ignored.
      configure(16'hFFFF, 16'd2, 16'd3, 16'd4, 16'd5);
      write_csr(CSR_UNMAPPED, 16'hA5A5);
      run_phase(RANDOM_PER_PHASE);

      // All sizes one, then a single wide dimension.
      configure(16'd3, 16'd1, 16'd1, 16'd1, 16'd1);
      run_phase(RANDOM_PER_PHASE / 2);
      configure(16'd1, 16'hFFFF, 16'd1, 16'd1, 16'd1);
      run_phase(RANDOM_PER_PHASE / 2);

      // Power-of-two sizes whose product is exactly 2^31.
      configure(16'd4, 16'd256, 16'd256, 16'd256, 16'd128);
      run_phase(RANDOM_PER_PHASE);

      // Random settings, small sizes most of the time.
      for (int k = 0; k < 3; k++) begin
         configure(16'($urandom_range(0, 7)),
                   16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40)),
                   16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40)),
                   16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40)),
                   16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40)));
         run_phase(RANDOM_PER_PHASE);
      end

      // Closing stretch at full rate with no idling on either side.
      quiet = 1'b1;
      configure(16'd2, 16'd1000, 16'd700, 16'd1, 16'd1);
      run_phase(RANDOM_PER_PHASE);

      $display("covered %0d requests and %0d checked responses over 13 register settings,",
               sent, board.checked);
      $display("including zero and oversize dimension counts, zero sizes and overflow.");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("mixed_radix_index_converter_test OK");
      end else begin
         $display("mixed_radix_index_converter_test NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* mixed_radix_index_converter.f */
src/mric_pkg.sv
src/mric_horner_cell.sv
src/mric_div_cell.sv
src/mixed_radix_index_converter.sv
tb/mixed_radix_index_converter_test.sv
